@@ hw/rtl/sfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find and replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int MAX_REPLACE = 8;
    localparam int JOB_DEPTH   = 8;

    localparam logic [1:0] REG_FIND_PATTERN   = 2'd0;
    localparam logic [1:0] REG_FIND_LENGTH    = 2'd1;
    localparam logic [1:0] REG_REPLACE_TEXT   = 2'd2;
    localparam logic [1:0] REG_REPLACE_LENGTH = 2'd3;

    typedef struct packed {
        logic [63:0] find_pattern;
        logic [3:0]  find_length;
        logic [63:0] replace_text;
        logic [3:0]  replace_length;
        logic        flush;
    } cfg_t;

    typedef struct packed {
        logic [JOB_DEPTH-1:0][7:0] data;
        logic [3:0]                count;
        logic                      last;
        logic                      marker;
    } job_t;

endpackage

@@ hw/rtl/sfr_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_cfg
// APB register file: pattern, pattern length, replacement, replacement length.
// ----------------------------------------------------------------------------
module sfr_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    output sfr_pkg::cfg_t cfg
);
    import sfr_pkg::*;

    logic [63:0] find_pattern_reg;
    logic [3:0]  find_length_reg;
    logic [63:0] replace_text_reg;
    logic [3:0]  replace_length_reg;
    logic        flush_reg;
    logic        wr_en;
    logic [1:0]  wr_index;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign wr_index = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            find_pattern_reg   <= '0;
            find_length_reg    <= '0;
            replace_text_reg   <= '0;
            replace_length_reg <= '0;
            flush_reg          <= 1'b0;
        end else begin
            flush_reg <= 1'b0;
            if (wr_en) begin
                case (wr_index)
                    REG_FIND_PATTERN: begin
                        find_pattern_reg <= pwdata;
                        flush_reg        <= 1'b1;
                    end
                    REG_FIND_LENGTH: begin
                        find_length_reg <= pwdata[3:0];
                        flush_reg       <= 1'b1;
                    end
                    REG_REPLACE_TEXT:   replace_text_reg   <= pwdata;
                    REG_REPLACE_LENGTH: replace_length_reg <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (wr_index)
            REG_FIND_PATTERN:   prdata = find_pattern_reg;
            REG_FIND_LENGTH:    prdata = {60'd0, find_length_reg};
            REG_REPLACE_TEXT:   prdata = replace_text_reg;
            REG_REPLACE_LENGTH: prdata = {60'd0, replace_length_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.find_pattern   = find_pattern_reg;
    assign cfg.find_length    = find_length_reg;
    assign cfg.replace_text   = replace_text_reg;
    assign cfg.replace_length = replace_length_reg;
    assign cfg.flush          = flush_reg;

endmodule

@@ hw/rtl/sfr_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_window
// Match window: appends each word, compares against the pattern in parallel
// and builds the list of bytes to emit for that word.
// ----------------------------------------------------------------------------
module sfr_window (
    input  logic          aclk,
    input  logic          aresetn,
    input  sfr_pkg::cfg_t cfg,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output sfr_pkg::job_t job
);
    import sfr_pkg::*;

    logic [7:0] win_reg  [MAX_PATTERN];
    logic [7:0] win_next [MAX_PATTERN];
    logic [7:0] wn       [MAX_PATTERN];
    logic [3:0] fill_reg;
    logic [3:0] fill_next;
    logic [3:0] len;
    logic [3:0] rlen;
    logic [2:0] pos;
    logic [3:0] nf;
    logic       full;
    logic       hit;
    logic [3:0] cnt;

    assign len  = (cfg.find_length > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : cfg.find_length;
    assign rlen = (cfg.replace_length > 4'(MAX_REPLACE)) ? 4'(MAX_REPLACE)
                                                          : cfg.replace_length;
    assign pos  = (fill_reg >= len) ? 3'd0 : fill_reg[2:0];
    assign nf   = {1'b0, pos} + 4'd1;
    assign full = (nf == len);

    always_comb begin
        hit = full;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            wn[i] = (pos == 3'(i)) ? in_byte : win_reg[i];
            if ((4'(i) < len) && (wn[i] != cfg.find_pattern[8*i +: 8])) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        job = '0;
        cnt = 4'd0;
        if (len == 4'd0) begin
            job.data[0] = in_byte;
            cnt         = 4'd1;
        end else if (hit) begin
            for (int i = 0; i < JOB_DEPTH; i++) begin
                job.data[i] = cfg.replace_text[8*i +: 8];
            end
            cnt = rlen;
        end else begin
            for (int i = 0; i < JOB_DEPTH; i++) begin
                job.data[i] = wn[i];
            end
            if (in_last) begin
                cnt = nf;
            end else if (full) begin
                cnt = 4'd1;
            end
        end
        job.last = in_last;
        if (in_last && (cnt == 4'd0)) begin
            job.data[0] = 8'h00;
            job.marker  = 1'b1;
            cnt         = 4'd1;
        end
        job.count = cnt;
    end

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            win_next[i] = win_reg[i];
        end
        fill_next = fill_reg;
        if (accept && (len != 4'd0)) begin
            if (hit || in_last) begin
                fill_next = 4'd0;
            end else if (full) begin
                for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                    win_next[i] = wn[i+1];
                end
                fill_next = len - 4'd1;
            end else begin
                win_next[pos] = in_byte;
                fill_next     = nf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 4'd0;
        end else if (cfg.flush) begin
            fill_reg <= 4'd0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule

@@ hw/rtl/sfr_serializer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_serializer
// Holds the emit list of one word and sends it one byte per cycle, while
// m_ready does not stall it, through an output register.
// ----------------------------------------------------------------------------
module sfr_serializer (
    input  logic          aclk,
    input  logic          aresetn,
    input  sfr_pkg::job_t job,
    input  logic          push,
    output logic          can_push,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_out_valid,
    output logic          m_out_last
);
    import sfr_pkg::*;

    job_t       job_reg;
    job_t       job_next;
    logic       out_load;
    logic       pop;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       flag_reg;
    logic       last_reg;

    assign out_load = !valid_reg || m_ready;
    assign pop      = out_load && (job_reg.count != 4'd0);
    assign can_push = (job_reg.count == 4'd0) || ((job_reg.count == 4'd1) && out_load);

    always_comb begin
        job_next = job_reg;
        if (push) begin
            job_next = job;
        end else if (pop) begin
            for (int i = 0; i < JOB_DEPTH - 1; i++) begin
                job_next.data[i] = job_reg.data[i+1];
            end
            job_next.count = job_reg.count - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg   <= '0;
            valid_reg <= 1'b0;
            byte_reg  <= 8'h00;
            flag_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            job_reg <= job_next;
            if (pop) begin
                valid_reg <= 1'b1;
                byte_reg  <= job_reg.marker ? 8'h00 : job_reg.data[0];
                flag_reg  <= !job_reg.marker;
                last_reg  <= job_reg.last && (job_reg.count == 4'd1);
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_out_valid = flag_reg;
    assign m_out_last  = last_reg;

endmodule

@@ hw/rtl/stream_find_and_replace.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Byte stream find and replace with a configurable pattern and replacement.
// Path: a word's first result passes the job and then the output register.
// Throughput: one word per cycle while each word yields at most one byte and
// m_ready is high; a word yielding more bytes holds the input (output serializer).
// Reset: synchronous, active low; clears registers, window fill and outputs.
// ----------------------------------------------------------------------------
module stream_find_and_replace (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_valid,
    output logic        m_out_last
);
    import sfr_pkg::*;

    cfg_t cfg;
    job_t job;
    logic accept;

    assign accept = s_valid && s_ready;

    sfr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfr_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .job     (job)
    );

    sfr_serializer u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job         (job),
        .push        (accept),
        .can_push    (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_valid (m_out_valid),
        .m_out_last  (m_out_last)
    );

endmodule

@@ tb/tb_stream_find_and_replace.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_find_and_replace
// Self-checking bench for the stream find and replace block. A scoreboard
// class tracks the register settings and the unsent window, predicts every
// output word from each accepted input word and checks the output stream in
// order. Directed texts cover pass-through, matches at the text end, deletion,
// the empty end marker, oversized lengths and reconfiguration in mid-text;
// random texts seeded with full and partial pattern copies follow, under
// random stalls on both channels in all phases but one.
// ----------------------------------------------------------------------------
module tb_stream_find_and_replace;

    import sfr_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } out_word_t;

    class rewrite_tracker;
        logic [63:0] pattern;
        logic [3:0]  find_len;
        logic [63:0] replacement;
        logic [3:0]  repl_len;
        logic [7:0]  win [MAX_PATTERN];
        int          fill;
        out_word_t   pending_out [$];
        int          errors;

        function new();
            pattern     = '0;
            find_len    = '0;
            replacement = '0;
            repl_len    = '0;
            fill        = 0;
            errors      = 0;
        endfunction

        function void add_expected(input out_word_t w);
            pending_out.insert(pending_out.size(), w);
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [63:0] value);
            case (idx)
                REG_FIND_PATTERN: begin
                    pattern = value;
                    fill = 0;
                end
                REG_FIND_LENGTH: begin
                    find_len = value[3:0];
                    fill = 0;
                end
                REG_REPLACE_TEXT: begin
                    replacement = value;
                end
                REG_REPLACE_LENGTH: begin
                    repl_len = value[3:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void take_byte(input logic [7:0] b, input logic last);
            int len;
            int rl;
            int n;
            int i;
            bit hit;
            out_word_t w;
            len = (find_len > MAX_PATTERN) ? MAX_PATTERN : find_len;
            n = 0;
            if (len == 0) begin
                w = '{b, 1'b1, last};
                add_expected(w);
                return;
            end
            if (fill >= len)
                fill = 0;
            win[fill] = b;
            fill++;
            if (fill == len) begin
                hit = 1;
                for (i = 0; i < len; i++)
                    if (win[i] != pattern[8*i +: 8])
                        hit = 0;
                if (hit) begin
                    rl = (repl_len > MAX_REPLACE) ? MAX_REPLACE : repl_len;
                    for (i = 0; i < rl; i++) begin
                        w = '{replacement[8*i +: 8], 1'b1, 1'b0};
                        add_expected(w);
                    end
                    n += rl;
                    fill = 0;
                end else begin
                    w = '{win[0], 1'b1, 1'b0};
                    add_expected(w);
                    n++;
                    for (i = 1; i < fill; i++)
                        win[i-1] = win[i];
                    fill--;
                end
            end
            if (last) begin
                for (i = 0; i < fill; i++) begin
                    w = '{win[i], 1'b1, 1'b0};
                    add_expected(w);
                    n++;
                end
                fill = 0;
                if (n == 0) begin
                    w = '{8'h00, 1'b0, 1'b1};
                    add_expected(w);
                end else begin
                    w = pending_out[pending_out.size() - 1];
                    w.last = 1'b1;
                    pending_out[pending_out.size() - 1] = w;
                end
            end
        endfunction

        function void check_out(input logic [7:0] data, input logic valid,
                                input logic last);
            out_word_t e;
            if (pending_out.size() == 0) begin
                $error("unexpected word: out_byte %0h out_valid %0b out_last %0b",
                       data, valid, last);
                errors++;
                return;
            end
            e = pending_out.pop_front();
            if (data !== e.data) begin
                $error("out_byte expected %0h actual %0h", e.data, data);
                errors++;
            end
            if (valid !== e.valid) begin
                $error("out_valid expected %0b actual %0b", e.valid, valid);
                errors++;
            end
            if (last !== e.last) begin
                $error("out_last expected %0b actual %0b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [4:0]  paddr       = '0;
    logic [63:0] pwdata      = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte   = '0;
    logic        s_in_last   = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_out_valid;
    logic        m_out_last;

    rewrite_tracker tracker;
    bit             no_gaps = 0;
    int             idle_cycles = 0;
    logic [7:0]     alpha [4];

    stream_find_and_replace DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_valid (m_out_valid),
        .m_out_last  (m_out_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        s_in_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_byte(b, last);
    endtask

    // input held off until all predicted words are out, then latency slack
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.pending_out.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(idx, value);
        @(posedge aclk);
    endtask

    function automatic logic [63:0] alpha_bytes();
        logic [63:0] v;
        int i;
        for (i = 0; i < 8; i++)
            v[8*i +: 8] = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                       : alpha[2'($urandom_range(0, 3))];
        return v;
    endfunction

    function automatic logic [63:0] random_reg_value(input logic [1:0] idx);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case (idx)
            REG_FIND_PATTERN:   v = alpha_bytes();
            REG_FIND_LENGTH:    v[3:0] = ($urandom_range(0, 3) == 0)
                                         ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(1, 4));
            REG_REPLACE_TEXT:   v = alpha_bytes();
            REG_REPLACE_LENGTH: v[3:0] = 4'($urandom_range(0, 15));
            default: begin
            end
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick_text_byte();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : alpha[2'($urandom_range(0, 3))];
    endfunction

    // text seeded with full and cut-short copies of the pattern
    task automatic send_text(input int n, inout int sent);
        int k;
        int plen;
        int copy_pos;
        int copy_len;
        logic [1:0] idx;
        logic [7:0] b;
        k = 0;
        copy_pos = 0;
        copy_len = 0;
        while (k < n) begin
            plen = (tracker.find_len > MAX_PATTERN) ? MAX_PATTERN : tracker.find_len;
            if (copy_pos >= copy_len && plen > 0 && $urandom_range(0, 2) == 0) begin
                copy_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : plen;
                copy_pos = 0;
            end
            if (copy_pos < copy_len && copy_pos < plen) begin
                b = tracker.pattern[8*copy_pos +: 8];
                copy_pos++;
            end else begin
                copy_len = 0;
                b = pick_text_byte();
            end
            send_word(b, k == n - 1);
            k++;
            sent++;
            if (k < n && $urandom_range(0, 29) == 0) begin
                settle();
                idx = 2'($urandom_range(0, 3));
                write_register(idx, random_reg_value(idx));
                copy_len = 0;
            end
        end
    endtask

    initial begin
        wait (aresetn);
        forever begin
            int gap;
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            tracker.check_out(m_out_byte, m_out_valid, m_out_last);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int phase;
        int sent;
        int i;
        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pass-through with reset settings
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        settle();

        // "ab" -> "XYZ", match at the end of the text
        write_register(REG_FIND_PATTERN, 64'h6261);
        write_register(REG_FIND_LENGTH, 64'd2);
        write_register(REG_REPLACE_TEXT, 64'h5A5958);
        write_register(REG_REPLACE_LENGTH, 64'd3);
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b0);
        send_word(8'h63, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b1);
        send_word(8'h61, 1'b1);
        settle();

        // deletion leaves nothing, so only the end marker comes out
        write_register(REG_REPLACE_LENGTH, 64'd0);
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b1);
        settle();

        // oversized lengths clamp to eight
        write_register(REG_FIND_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(REG_FIND_LENGTH, 64'hF);
        write_register(REG_REPLACE_TEXT, 64'h0011_2233_4455_6677);
        write_register(REG_REPLACE_LENGTH, 64'hF);
        for (i = 0; i < 8; i++)
            send_word(8'hFF, i == 7);
        settle();

        // pattern rewrite drops the held window, replacement rewrite keeps it
        write_register(REG_FIND_PATTERN, 64'h636261);
        write_register(REG_FIND_LENGTH, 64'd3);
        write_register(REG_REPLACE_TEXT, 64'h2A);
        write_register(REG_REPLACE_LENGTH, 64'd1);
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b0);
        settle();
        write_register(REG_FIND_PATTERN, 64'h636261);
        send_word(8'h7A, 1'b1);
        send_word(8'h61, 1'b0);
        send_word(8'h62, 1'b0);
        settle();
        write_register(REG_REPLACE_TEXT, 64'h21);
        send_word(8'h63, 1'b1);
        settle();

        for (phase = 0; phase < 8; phase++) begin
            no_gaps = (phase == 3);
            for (i = 0; i < 4; i++)
                alpha[i] = 8'($urandom_range(0, 255));
            if (phase == 0) begin
                alpha[0] = 8'h00;
                write_register(REG_FIND_PATTERN, 64'h0);
                write_register(REG_FIND_LENGTH, 64'd1);
                write_register(REG_REPLACE_TEXT, 64'h0);
                write_register(REG_REPLACE_LENGTH, 64'd0);
            end else if (phase == 7) begin
                alpha[0] = 8'hFF;
                write_register(REG_FIND_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
                write_register(REG_FIND_LENGTH, 64'd8);
                write_register(REG_REPLACE_TEXT, 64'hFFFF_FFFF_FFFF_FFFF);
                write_register(REG_REPLACE_LENGTH, 64'd8);
            end else begin
                write_register(REG_FIND_PATTERN, random_reg_value(REG_FIND_PATTERN));
                write_register(REG_FIND_LENGTH, random_reg_value(REG_FIND_LENGTH));
                write_register(REG_REPLACE_TEXT, random_reg_value(REG_REPLACE_TEXT));
                write_register(REG_REPLACE_LENGTH, random_reg_value(REG_REPLACE_LENGTH));
            end
            sent = 0;
            while (sent < 52)
                send_text(($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                      : $urandom_range(1, 20), sent);
            settle();
        end

        no_gaps = 0;
        settle();
        repeat (20) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending_out.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
